### src/pixsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pixsn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PIXEL_COUNT = 64;
  localparam int CHAN_COUNT  = 3;
  localparam int SLOT_COUNT  = PIXEL_COUNT * CHAN_COUNT;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int PIXEL_W     = 6;
  localparam int LEVEL_W     = FRAC_BITS + 1;
  localparam int STORE_W     = FRAC_BITS + 4;
  localparam int WORK_W      = FRAC_BITS + 8;
  localparam int PROD_W      = STORE_W + LEVEL_W + 3;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic signed [WORK_W-1:0] ONE_W  = WORK_W'(1 << FRAC_BITS);
  localparam logic signed [WORK_W-1:0] HALF_W = WORK_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [WORK_W-1:0] STORE_MAX_W = WORK_W'((1 << (STORE_W - 1)) - 1);
  localparam logic signed [WORK_W-1:0] STORE_MIN_W = WORK_W'(-(1 << (STORE_W - 1)));
  localparam logic [LEVEL_W-1:0] ONE_L = LEVEL_W'(1 << FRAC_BITS);

  // channel codes
  localparam logic [1:0] CMD_HUE  = 2'd0;
  localparam logic [1:0] CMD_SAT  = 2'd1;
  localparam logic [1:0] CMD_VAL  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_KICK    = 2'd0;
  localparam logic [1:0] REG_RESTORE = 2'd1;
  localparam logic [1:0] REG_FRIC    = 2'd2;
  localparam logic [1:0] REG_TEMP    = 2'd3;

  typedef struct packed {
    logic [PIXEL_W-1:0]   pixel;
    logic [1:0]           command;
    logic [LEVEL_W-1:0]   target;
    logic [LEVEL_W-1:0]   tolerance;
    logic [FRAC_BITS-1:0] random_fraction;
  } in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic [1:0]         channel_out;
    logic [LEVEL_W-1:0] level;
  } out_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] kick_step;
    logic [FRAC_BITS-1:0] restore_step;
    logic [FRAC_BITS-1:0] friction;
    logic [LEVEL_W-1:0]   temperature;
  } cfg_t;

  typedef struct packed {
    logic signed [STORE_W-1:0] pos;
    logic signed [STORE_W-1:0] vel;
  } state_t;

  // entry pixel*3+channel; the unused command maps onto the hue entry
  function automatic logic [SLOT_W-1:0] slot_of(input logic [PIXEL_W-1:0] pixel,
                                                input logic [1:0] command);
    logic [1:0] chan;
    chan = (command == CMD_NONE) ? CMD_HUE : command;
    return SLOT_W'({pixel, 1'b0}) + SLOT_W'(pixel) + SLOT_W'(chan);
  endfunction

endpackage
`default_nettype wire

### src/pixsn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pixsn_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/pixsn_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module pixsn_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pixsn_pkg::CFG_AW-1:0] paddr,
  input  wire logic [pixsn_pkg::CFG_DW-1:0] pwdata,
  output      logic [pixsn_pkg::CFG_DW-1:0] prdata,
  output      logic                        pready,
  output      pixsn_pkg::cfg_t             cfg
);

  pixsn_pkg::cfg_t cfg_r;
  pixsn_pkg::cfg_t cfg_nxt;
  logic [1:0]      idx;
  logic            wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        pixsn_pkg::REG_KICK:    cfg_nxt.kick_step    = pwdata[pixsn_pkg::FRAC_BITS-1:0];
        pixsn_pkg::REG_RESTORE: cfg_nxt.restore_step = pwdata[pixsn_pkg::FRAC_BITS-1:0];
        pixsn_pkg::REG_FRIC:    cfg_nxt.friction     = pwdata[pixsn_pkg::FRAC_BITS-1:0];
        pixsn_pkg::REG_TEMP:    cfg_nxt.temperature  = pwdata[pixsn_pkg::LEVEL_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kick_step    <= pixsn_pkg::FRAC_BITS'(655);
      cfg_r.restore_step <= pixsn_pkg::FRAC_BITS'(655);
      cfg_r.friction     <= pixsn_pkg::FRAC_BITS'(62259);
      cfg_r.temperature  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      pixsn_pkg::REG_KICK:    prdata = pixsn_pkg::CFG_DW'(cfg_r.kick_step);
      pixsn_pkg::REG_RESTORE: prdata = pixsn_pkg::CFG_DW'(cfg_r.restore_step);
      pixsn_pkg::REG_FRIC:    prdata = pixsn_pkg::CFG_DW'(cfg_r.friction);
      pixsn_pkg::REG_TEMP:    prdata = pixsn_pkg::CFG_DW'(cfg_r.temperature);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/pixsn_step.sv
`timescale 1ns / 1ps
`default_nettype none
module pixsn_step (
  input  wire pixsn_pkg::cfg_t                        cfg,
  input  wire logic [1:0]                             command,
  input  wire logic [pixsn_pkg::LEVEL_W-1:0]          target,
  input  wire logic [pixsn_pkg::LEVEL_W-1:0]          tolerance,
  input  wire logic [pixsn_pkg::FRAC_BITS-1:0]        random_fraction,
  input  wire pixsn_pkg::state_t                      cur,
  output      pixsn_pkg::state_t                      nxt,
  output      logic [pixsn_pkg::LEVEL_W-1:0]          level
);

  localparam int W  = pixsn_pkg::WORK_W;
  localparam int SW = pixsn_pkg::STORE_W;
  localparam int LW = pixsn_pkg::LEVEL_W;
  localparam int FB = pixsn_pkg::FRAC_BITS;
  localparam int PW = pixsn_pkg::PROD_W;

  logic                  wraps;
  logic signed [W-1:0]   tgt_raw, tgt_w, tol_w, inv_w;
  logic signed [W-1:0]   pos_ext, vel_ext, pos_a;
  logic signed [W-1:0]   kick_w, rest_w, step0, step1, step2;
  logic signed [W-1:0]   upper_w, lower_w, vsum_w, vel_s, pos_b;
  logic [LW-1:0]         rnd2;
  logic [LW-1:0]         rnd_l;
  logic signed [PW-1:0]  vel_p, fric_p, prod_w, prod_adj, prod_sh;
  logic [LW-1:0]         pos_c;

  always_comb begin
    wraps   = (command == pixsn_pkg::CMD_HUE);
    tgt_raw = $signed(W'(target));
    tol_w   = $signed(W'(tolerance));
    pos_ext = W'(cur.pos);
    vel_ext = W'(cur.vel);

    // hue: pull position within half a turn of the target
    inv_w = tgt_raw + pixsn_pkg::HALF_W;
    tgt_w = (wraps && tgt_raw > pixsn_pkg::ONE_W) ? tgt_raw - pixsn_pkg::ONE_W : tgt_raw;
    pos_a = (wraps && pos_ext > inv_w) ? pos_ext - pixsn_pkg::ONE_W : pos_ext;

    // temperature kick
    kick_w = $signed(W'(cfg.kick_step));
    rest_w = $signed(W'(cfg.restore_step));
    rnd_l  = LW'(random_fraction);
    rnd2   = {random_fraction, 1'b0};
    step0  = '0;
    if (rnd_l <= cfg.temperature) begin
      if (rnd2 < cfg.temperature) begin
        step0 = -kick_w;
      end else if (rnd2 > cfg.temperature) begin
        step0 = kick_w;
      end
    end

    // restoring push outside the dead band; downward only on hue or zero target
    upper_w = tgt_w + tol_w;
    lower_w = tgt_w - tol_w;
    step1 = ((wraps || tgt_w == '0) && pos_a > upper_w) ? step0 - rest_w : step0;
    step2 = (pos_a < lower_w) ? step1 + rest_w : step1;

    vsum_w = vel_ext + step2;
    if (vsum_w > pixsn_pkg::STORE_MAX_W) begin
      vel_s = pixsn_pkg::STORE_MAX_W;
    end else if (vsum_w < pixsn_pkg::STORE_MIN_W) begin
      vel_s = pixsn_pkg::STORE_MIN_W;
    end else begin
      vel_s = vsum_w;
    end
    pos_b = pos_a + vel_s;

    // friction, truncated toward zero
    vel_p    = PW'(vel_s);
    fric_p   = $signed(PW'(cfg.friction));
    prod_w   = vel_p * fric_p;
    prod_adj = (prod_w < 0) ? prod_w + $signed(PW'((1 << FB) - 1)) : prod_w;
    prod_sh  = prod_adj >>> FB;

    if (wraps) begin
      if (pos_b < 0) begin
        pos_c = LW'(pos_b[FB-1:0]);
      end else if (pos_b > pixsn_pkg::ONE_W) begin
        pos_c = (pos_b[FB-1:0] == '0) ? pixsn_pkg::ONE_L : LW'(pos_b[FB-1:0]);
      end else begin
        pos_c = pos_b[LW-1:0];
      end
    end else begin
      if (pos_b < 0) begin
        pos_c = '0;
      end else if (pos_b > pixsn_pkg::ONE_W) begin
        pos_c = pixsn_pkg::ONE_L;
      end else begin
        pos_c = pos_b[LW-1:0];
      end
    end

    nxt.pos = $signed(SW'(pos_c));
    nxt.vel = prod_sh[SW-1:0];
    level   = (command == pixsn_pkg::CMD_NONE) ? '0 : pos_c;
  end

endmodule
`default_nettype wire

### src/pixel_spring_noise_step_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A request accepted at a clock edge has its state read at accept; the update is computed
// in stage 1, then written and registered onto out_valid when stage 1 advances.
// Throughput: one request per cycle while out_ready does not stall the output, set by the
// single read-modify-write of the state RAM per cycle; a bypass register covers back-to-back
// hits on the same entry. Reset: registers go to their defaults and per-entry valid bits
// clear, so every position and velocity reads as zero at once; no clearing pass.
module pixel_spring_noise_step_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire pixsn_pkg::in_t               in_data,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      pixsn_pkg::out_t              out_data,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [pixsn_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pixsn_pkg::CFG_DW-1:0] cfg_pwdata,
  output      logic [pixsn_pkg::CFG_DW-1:0] cfg_prdata,
  output      logic                         cfg_pready
);

  localparam int SLW = pixsn_pkg::SLOT_W;

  pixsn_pkg::cfg_t   cfg;
  pixsn_pkg::in_t    s1_data_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [SLW-1:0]    s1_slot_r;
  logic              s1_hit_r;
  logic              byp_r, byp_nxt;
  pixsn_pkg::state_t byp_data_r;
  logic [pixsn_pkg::SLOT_COUNT-1:0] slot_vld_r;
  logic              out_valid_r;
  pixsn_pkg::out_t   out_data_r;

  logic              accept, s1_adv, wr_en;
  logic [SLW-1:0]    rd_slot;
  logic [$bits(pixsn_pkg::state_t)-1:0] ram_rdata;
  pixsn_pkg::state_t cur, upd;
  logic [pixsn_pkg::LEVEL_W-1:0] level;

  pixsn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign rd_slot  = pixsn_pkg::slot_of(in_data.pixel, in_data.command);
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign wr_en    = s1_adv && (s1_data_r.command != pixsn_pkg::CMD_NONE);
  assign byp_nxt  = wr_en && (s1_slot_r == rd_slot);

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  pixsn_ram #(
    .WIDTH ($bits(pixsn_pkg::state_t)),
    .DEPTH (pixsn_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_slot_r),
    .wdata (upd),
    .re    (accept),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  // forward the entry just written, else the RAM data for a written entry, else zero for an entry never written
  always_comb begin
    if (byp_r) begin
      cur = byp_data_r;
    end else if (s1_hit_r) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
  end

  pixsn_step u_step (
    .cfg             (cfg),
    .command         (s1_data_r.command),
    .target          (s1_data_r.target),
    .tolerance       (s1_data_r.tolerance),
    .random_fraction (s1_data_r.random_fraction),
    .cur             (cur),
    .nxt             (upd),
    .level           (level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      slot_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        byp_r <= byp_nxt;
      end
      if (wr_en) begin
        slot_vld_r[s1_slot_r] <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r  <= in_data;
      s1_slot_r  <= rd_slot;
      s1_hit_r   <= slot_vld_r[rd_slot];
      byp_data_r <= upd;
    end
    if (s1_adv) begin
      out_data_r.pixel_out   <= s1_data_r.pixel;
      out_data_r.channel_out <= s1_data_r.command;
      out_data_r.level       <= level;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request did not reach the output register");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> slot_vld_r[$past(s1_slot_r)])
    else $error("written entry not marked valid");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.level <= pixsn_pkg::ONE_L)
    else $error("level above one");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.channel_out == pixsn_pkg::CMD_NONE)
      |-> out_data_r.level == '0)
    else $error("unused command gave a nonzero level");

endmodule
`default_nettype wire

### tb/pixel_spring_noise_step_check.sv
`timescale 1ns / 1ps
module pixel_spring_noise_step_check
  import pixsn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire in_t               in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire out_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  input  wire logic              cfg_pready,
  output int                     mismatch_count,
  output int                     levels_owed
);

  typedef logic signed [47:0] wide_t;

  localparam wide_t UNIT    = wide_t'(1 << FRAC_BITS);
  localparam wide_t HALF    = wide_t'(1 << (FRAC_BITS - 1));
  localparam wide_t VEL_MAX = wide_t'((1 << (STORE_W - 1)) - 1);
  localparam wide_t VEL_MIN = -wide_t'(1 << (STORE_W - 1));

  logic [FRAC_BITS-1:0]      kick_r;
  logic [FRAC_BITS-1:0]      restore_r;
  logic [FRAC_BITS-1:0]      friction_r;
  logic [LEVEL_W-1:0]        temp_r;
  logic signed [STORE_W-1:0] pos_mem [SLOT_COUNT];
  logic signed [STORE_W-1:0] vel_mem [SLOT_COUNT];
  out_t                      pending_levels [$];

  // One noisy spring step on the addressed entry; updates the local state copy.
  function automatic out_t spring_update(input in_t req);
    out_t                 res;
    int                   idx;
    logic                 hue;
    logic [FRAC_BITS-1:0] frac;
    wide_t                pos, vel, step, tgt, tol, inv, rnd, temp, prod, rem;
    res.pixel_out   = req.pixel;
    res.channel_out = req.command;
    res.level       = '0;
    if (req.command == CMD_NONE) begin
      return res;
    end
    idx  = int'(req.pixel) * CHAN_COUNT + int'(req.command);
    pos  = wide_t'(pos_mem[idx]);
    vel  = wide_t'(vel_mem[idx]);
    tgt  = wide_t'(req.target);
    tol  = wide_t'(req.tolerance);
    rnd  = wide_t'(req.random_fraction);
    temp = wide_t'(temp_r);
    hue  = (req.command == CMD_HUE);
    // align hue onto the short arc; threshold uses the target as given
    if (hue) begin
      inv = tgt + HALF;
      if (tgt > UNIT) tgt = tgt - UNIT;
      if (pos > inv) pos = pos - UNIT;
    end
    step = '0;
    if (rnd <= temp) begin
      if (2 * rnd < temp) step = -wide_t'(kick_r);
      else if (2 * rnd > temp) step = wide_t'(kick_r);
    end
    // push down only where the channel wraps or the target is zero
    if ((hue || tgt == 0) && pos > tgt + tol) step = step - wide_t'(restore_r);
    if (pos < tgt - tol) step = step + wide_t'(restore_r);
    vel = vel + step;
    if (vel > VEL_MAX) vel = VEL_MAX;
    if (vel < VEL_MIN) vel = VEL_MIN;
    pos  = pos + vel;
    prod = vel * wide_t'(friction_r);
    vel  = (prod >= 0) ? (prod >>> FRAC_BITS) : -((-prod) >>> FRAC_BITS);
    if (hue) begin
      if (pos < 0) begin
        frac = pos[FRAC_BITS-1:0];
        pos  = wide_t'(frac);
      end else if (pos > UNIT) begin
        rem  = pos - UNIT;
        frac = rem[FRAC_BITS-1:0];
        pos  = (frac == 0) ? UNIT : wide_t'(frac);
      end
    end else begin
      if (pos < 0) pos = '0;
      if (pos > UNIT) pos = UNIT;
    end
    pos_mem[idx] = pos[STORE_W-1:0];
    vel_mem[idx] = vel[STORE_W-1:0];
    res.level    = pos[LEVEL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      kick_r     = 16'd655;
      restore_r  = 16'd655;
      friction_r = 16'd62259;
      temp_r     = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pos_mem[i] = '0;
        vel_mem[i] = '0;
      end
      pending_levels.delete();
      mismatch_count = 0;
      levels_owed    = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_KICK:    kick_r     = cfg_pwdata[FRAC_BITS-1:0];
          REG_RESTORE: restore_r  = cfg_pwdata[FRAC_BITS-1:0];
          REG_FRIC:    friction_r = cfg_pwdata[FRAC_BITS-1:0];
          REG_TEMP:    temp_r     = cfg_pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_levels.size() == 0) begin
          $error("unexpected result: pixel_out %0d channel_out %0d level %0d",
                 out_data.pixel_out, out_data.channel_out, out_data.level);
          mismatch_count++;
        end else begin
          want = pending_levels.pop_front();
          if (out_data.pixel_out !== want.pixel_out) begin
            $error("pixel_out mismatch: expected %0d actual %0d",
                   want.pixel_out, out_data.pixel_out);
            mismatch_count++;
          end
          if (out_data.channel_out !== want.channel_out) begin
            $error("channel_out mismatch: expected %0d actual %0d",
                   want.channel_out, out_data.channel_out);
            mismatch_count++;
          end
          if (out_data.level !== want.level) begin
            $error("level mismatch: expected %0d actual %0d", want.level, out_data.level);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_levels.push_back(spring_update(in_data));
      end
      levels_owed = pending_levels.size();
    end
  end

endmodule

### tb/pixel_spring_noise_step_core_tb.sv
`timescale 1ns / 1ps
module pixel_spring_noise_step_core_tb;
  import pixsn_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatch_count;
  int                levels_owed;
  int                burst_left;
  int                cur_temp;

  pixel_spring_noise_step_core uut (.*);

  pixel_spring_noise_step_check chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatch_count, .levels_owed
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("pixel_spring_noise_step_core_tb: FAIL");
    $finish;
  end

  // receiver: out_ready follows one of four randomly picked stall modes
  initial begin
    int cyc;
    int stall_mode;
    out_ready  = 1'b0;
    cyc        = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (cyc % 96 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 1) == 0);
        default: out_ready <= ((cyc % 11) < 4);
      endcase
      cyc++;
    end
  end

  function automatic in_t make_request(input int pixel, input logic [1:0] command,
                                       input int target, input int tolerance, input int rnd);
    in_t r;
    r.pixel           = PIXEL_W'(pixel);
    r.command         = command;
    r.target          = LEVEL_W'(target);
    r.tolerance       = LEVEL_W'(tolerance);
    r.random_fraction = FRAC_BITS'(rnd);
    return r;
  endfunction

  function automatic in_t random_request();
    int         pixel;
    logic [1:0] command;
    int         target;
    int         tolerance;
    int         rnd;
    // favor a few pixels so entries see long histories and back-to-back hits
    pixel   = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 63);
    command = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0:       target = 0;
      1:       target = 1 << FRAC_BITS;
      2:       target = $urandom_range(0, 131071);
      default: target = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(0, 9))
      0:       tolerance = 0;
      1:       tolerance = $urandom_range(0, 131071);
      2, 3, 4: tolerance = $urandom_range(0, 65536);
      default: tolerance = $urandom_range(0, 2048);
    endcase
    case ($urandom_range(0, 9))
      0:       rnd = cur_temp / 2;
      1:       rnd = (cur_temp > 65535) ? 65535 : cur_temp;
      2:       rnd = 0;
      3:       rnd = 65535;
      default: rnd = $urandom_range(0, 65535);
    endcase
    return make_request(pixel, command, target, tolerance, rnd);
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_temp();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // drop valid, hold until every request has its result, then let the pipe settle
  task automatic wait_for_levels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (levels_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int kick, input int restore, input int fric, input int temp);
    write_reg(REG_KICK, kick);
    write_reg(REG_RESTORE, restore);
    write_reg(REG_FRIC, fric);
    write_reg(REG_TEMP, temp);
    cur_temp = temp;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    burst_left  = 0;
    cur_temp    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset, no kicks
    send_request(make_request(0, CMD_HUE, 0, 0, 0));
    send_request(make_request(63, CMD_SAT, 65536, 0, 65535));
    send_request(make_request(63, CMD_VAL, 0, 0, 65535));
    send_request(make_request(63, CMD_NONE, 131071, 131071, 65535));
    send_request(make_request(0, CMD_HUE, 131071, 0, 0));
    send_request(make_request(1, CMD_HUE, 65536, 131071, 0));
    send_request(make_request(1, CMD_SAT, 32768, 0, 0));

    // strongest kicks, almost no friction loss: drive velocity into saturation
    wait_for_levels();
    set_config(65535, 65535, 65535, 65536);
    repeat (8) send_request(make_request(5, CMD_VAL, 131071, 0, 65535));
    repeat (6) send_request(make_request(6, CMD_HUE, 0, 0, 0));
    send_request(make_request(6, CMD_HUE, 65536, 0, 32768));
    send_request(make_request(7, CMD_SAT, 0, 0, 40000));

    // everything off: friction kills the velocity
    wait_for_levels();
    set_config(0, 0, 0, 0);
    send_request(make_request(5, CMD_VAL, 0, 0, 0));
    send_request(make_request(6, CMD_HUE, 32768, 100, 65535));

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_levels();
      if (phase == 0) set_config(655, 655, 62259, 65536);
      else set_config(pick_step(), pick_step(), pick_step(), pick_temp());
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 59) == 0) wait_for_levels();
        send_request(random_request());
      end
    end

    wait_for_levels();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && levels_owed == 0) begin
      $display("pixel_spring_noise_step_core_tb: PASS");
    end else begin
      $display("pixel_spring_noise_step_core_tb: FAIL");
    end
    $finish;
  end

endmodule
